// File: hdl/fmdx_pkg.sv
// Shared constants, codes and helpers for the FM-index interval extension core.
// No dependencies; imported by fmdx_ram users and the top level.
package fmdx_pkg;

    localparam int BASES             = 5;
    localparam int DEF_OCC_WORD_BITS = 64;
    localparam int DEF_MARK_INTERVAL = 8;
    localparam int DEF_OCC_WORDS     = 65536;
    localparam int MEM_WIDTH         = 64;
    localparam int GRP_W             = 40;
    localparam int CNT_W             = 32;

    localparam logic [2:0] ACT_LOAD    = 3'd0;
    localparam logic [2:0] ACT_BACK1   = 3'd1;
    localparam logic [2:0] ACT_FWD1    = 3'd2;
    localparam logic [2:0] ACT_BACKALL = 3'd3;
    localparam logic [2:0] ACT_FWDALL  = 3'd4;

    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;

    // Count ones of a 64-bit word
    function automatic logic [6:0] popcnt64(input logic [63:0] x);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < 64; i++) begin
            c = c + 7'(x[i]);
        end
        return c;
    endfunction

    // Complement a base: A<->T, C<->G, N stays
    function automatic logic [2:0] base_comp(input logic [2:0] b);
        logic [2:0] r;
        r = (b < BASE_N) ? (BASE_T - b) : BASE_N;
        return r;
    endfunction

endpackage

// File: hdl/fmd_index_interval_extension_core.sv
// Top level of the bidirectional FM-index interval extension core.
// Depends on fmdx_pkg and fmdx_ram (occurrence table storage).
//
// Usage: items enter on the s-side stream (tuser = action). A load beat writes one
// 64-bit table word in the cycle it is accepted, so loads stream one per cycle
// while the core is idle (the input is not ready during a query). A query beat
// extends an interval by one base (one result) or by all five bases (five
// results, tlast on the fifth). The cum_count registers are to be written on
// the cfg channel only while the core is idle; the core does not enforce this.
// One query is processed at a time: two rank lookups, each with setup, one
// memory read per word walked, five words for each of up to MARK_INTERVAL/2+1
// groups (25 reads at the default sizes), and a drain; then a combine step.
// Results enter the output register as it frees, and the input is ready again once
// the last result sits in the output register. OCC_WORD_BITS, MARK_INTERVAL and
// OCC_WORDS must be powers of two. When the receiver stalls, the output register
// holds the pending beat and the core waits before producing the next one.
// Reset (synchronous, active low) clears the control state and the count
// registers; the occurrence table is undefined until loaded.
module fmd_index_interval_extension_core #(
    parameter int OCC_WORD_BITS = fmdx_pkg::DEF_OCC_WORD_BITS,
    parameter int MARK_INTERVAL = fmdx_pkg::DEF_MARK_INTERVAL,
    parameter int OCC_WORDS     = fmdx_pkg::DEF_OCC_WORDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // load_addr[15:0], load_data[79:16], in_fwd_pos[111:80], in_rev_pos[143:112],
    // in_size[175:144], base[178:176], zero[183:179]
    input  logic [183:0] i_s_tdata,
    // action[2:0]
    input  logic [2:0]   i_s_tuser,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // out_fwd_pos[31:0], out_rev_pos[63:32], out_size[95:64], out_base[98:96],
    // zero[103:99]
    output logic [103:0] o_m_tdata,
    output logic         o_m_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import fmdx_pkg::*;

    localparam int AW  = $clog2(OCC_WORDS);
    localparam int BW  = $clog2(OCC_WORD_BITS);
    localparam int MSH = $clog2(MARK_INTERVAL);
    localparam int PW  = $clog2((MARK_INTERVAL + 2) * OCC_WORD_BITS + 1);
    localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - OCC_WORD_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_GRP, S_GSEL, S_WALK, S_DRAIN,
        S_FIN, S_NS, S_TOT, S_CMP, S_CHAIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CL_MARK, CL_PART, CL_FULL
    } t_cls;

    t_state r_state;

    // Item registers
    logic [CNT_W-1:0]  r_fp, r_rp, r_sz;
    logic [2:0]        r_b;
    logic              r_all, r_fwdm, r_which;
    logic [CNT_W-1:0]  r_cum [BASES];

    // Rank walk
    logic [GRP_W-1:0]  r_wn, r_gw, r_gm, r_g, r_gend;
    logic [BW-1:0]     r_bit;
    logic              r_fwd;
    logic [AW-1:0]     r_addr;
    logic [2:0]        r_j;
    logic              r_tag_vld;
    logic [2:0]        r_tag_j;
    t_cls              r_tag_cls;
    t_cls              cls;
    logic [63:0]       r_mark [BASES];
    logic [PW-1:0]     r_pop [BASES];
    logic [63:0]       r_lo [BASES];
    logic [63:0]       r_hi [BASES];

    // Combine
    logic [63:0]       r_ns [BASES];
    logic [CNT_W-1:0]  r_nf [BASES];
    logic [CNT_W-1:0]  r_nr [BASES];
    logic [63:0]       r_tot;
    logic [2:0]        r_k;

    // Output register
    logic              r_ovld, r_olast;
    logic [103:0]      r_odata;

    // Memory
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [63:0]       mem_rdata;

    // Intermediate values
    logic [CNT_W:0]    su_e, su_p;
    logic              su_neg1;
    logic [63:0]       w_masked, w_fpart, w_bpart;
    logic [6:0]        sh_f, sh_b;
    logic [6:0]        pop_full, pop_part;
    logic [2:0]        o_t, o_s;
    logic              gsel_fwd;
    logic [GRP_W-1:0]  gsel_gs, gs5, grp_q;
    logic              s_acc;
    logic              emit;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovld;
    assign o_m_tdata   = r_odata;
    assign o_m_tlast   = r_olast;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign emit        = (r_state == S_OUT) && (!r_ovld || i_m_tready);

    fmdx_ram #(
        .WIDTH (MEM_WIDTH),
        .DEPTH (OCC_WORDS)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_s_tdata[79:16]),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // Store a load beat straight from the input, address wrapped to the table
    assign mem_we    = s_acc && (i_s_tuser == ACT_LOAD);
    assign mem_waddr = AW'(i_s_tdata[15:0]);

    // Rank position for the current lookup
    always_comb begin
        su_e = {1'b0, r_fp} + {1'b0, r_sz};
        if (r_which) begin
            su_neg1 = (su_e == '0);
            su_p    = su_e - 1'b1;
        end else begin
            su_neg1 = (r_fp == '0);
            su_p    = {1'b0, r_fp} - 1'b1;
        end
    end

    // Group class and popcount of the word coming back from memory
    always_comb begin
        if (r_g == r_gm) begin
            cls = CL_MARK;
        end else if (r_g == r_gw) begin
            cls = CL_PART;
        end else begin
            cls = CL_FULL;
        end
        sh_f     = 7'(OCC_WORD_BITS - 1) - 7'(r_bit);
        sh_b     = 7'(r_bit) + 7'd1;
        w_masked = mem_rdata & WORD_MASK;
        w_fpart  = w_masked >> sh_f;
        w_bpart  = (7'(r_bit) < 7'(OCC_WORD_BITS - 1)) ? ((mem_rdata << sh_b) & WORD_MASK)
                                                         : '0;
        pop_full = popcnt64(w_masked);
        pop_part = popcnt64(r_fwd ? w_fpart : w_bpart);
    end

    // Nearest mark index, walk direction, first group and its word address
    always_comb begin
        grp_q    = (r_wn + GRP_W'(MARK_INTERVAL / 2)) >> MSH;
        gsel_fwd = (r_gw > r_gm);
        gsel_gs  = gsel_fwd ? r_gm : r_gw;
        gs5      = (gsel_gs << 2) + gsel_gs;
    end

    // Result symbol selection
    always_comb begin
        o_t = r_all ? r_k : r_b;
        o_s = r_fwdm ? base_comp(o_t) : o_t;
    end

    // Main sequencer, datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovld    <= 1'b0;
            r_tag_vld <= 1'b0;
            for (int j = 0; j < BASES; j++) begin
                r_cum[j] <= '0;
            end
        end else begin
            // Accept register writes
            if (i_cfg_valid && (32'(i_cfg_index) < 32'(BASES))) begin
                r_cum[i_cfg_index] <= i_cfg_data;
            end
            // Release the output beat once taken, unless a new one replaces it
            if (r_ovld && i_m_tready && !emit) begin
                r_ovld <= 1'b0;
            end
            // Fold the returning word into the rank
            r_tag_vld <= (r_state == S_WALK);
            if (r_tag_vld) begin
                case (r_tag_cls)
                    CL_MARK: r_mark[r_tag_j] <= mem_rdata;
                    CL_PART: r_pop[r_tag_j]  <= r_pop[r_tag_j] + PW'(pop_part);
                    default: r_pop[r_tag_j]  <= r_pop[r_tag_j] + PW'(pop_full);
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_sz    <= i_s_tdata[175:144];
                        r_b     <= (i_s_tdata[178:176] > BASE_N) ? BASE_N
                                                                 : i_s_tdata[178:176];
                        r_which <= 1'b0;
                        case (i_s_tuser)
                            ACT_BACK1, ACT_BACKALL: begin
                                r_fp    <= i_s_tdata[111:80];
                                r_rp    <= i_s_tdata[143:112];
                                r_fwdm  <= 1'b0;
                                r_all   <= (i_s_tuser == ACT_BACKALL);
                                r_state <= S_SETUP;
                            end
                            ACT_FWD1, ACT_FWDALL: begin
                                r_fp    <= i_s_tdata[143:112];
                                r_rp    <= i_s_tdata[111:80];
                                r_fwdm  <= 1'b1;
                                r_all   <= (i_s_tuser == ACT_FWDALL);
                                r_state <= S_SETUP;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SETUP: begin
                    for (int j = 0; j < BASES; j++) begin
                        r_pop[j] <= '0;
                    end
                    if (su_neg1) begin
                        // Position -1 reads the first mark group only
                        r_gm    <= '0;
                        r_gw    <= GRP_W'(1);
                        r_g     <= '0;
                        r_gend  <= '0;
                        r_fwd   <= 1'b1;
                        r_addr  <= '0;
                        r_j     <= '0;
                        r_state <= S_WALK;
                    end else begin
                        // Split the position into word number and bit
                        r_wn    <= GRP_W'(su_p >> BW);
                        r_bit   <= su_p[BW-1:0];
                        r_state <= S_GRP;
                    end
                end
                S_GRP: begin
                    // Word group and nearest mark group
                    r_gw    <= r_wn + (r_wn >> MSH) + GRP_W'(1);
                    r_gm    <= (grp_q << MSH) + grp_q;
                    r_state <= S_GSEL;
                end
                S_GSEL: begin
                    r_fwd   <= gsel_fwd;
                    r_g     <= gsel_gs;
                    r_gend  <= gsel_fwd ? r_gw : r_gm;
                    r_addr  <= gs5[AW-1:0];
                    r_j     <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_tag_j   <= r_j;
                    r_tag_cls <= cls;
                    r_addr    <= (r_addr == AW'(OCC_WORDS - 1)) ? '0 : r_addr + 1'b1;
                    if (r_j == 3'(BASES - 1)) begin
                        r_j <= '0;
                        r_g <= r_g + 1'b1;
                        if (r_g == r_gend) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_FIN;
                S_FIN: begin
                    for (int j = 0; j < BASES; j++) begin
                        if (r_which) begin
                            r_hi[j] <= r_fwd ? r_mark[j] + 64'(r_pop[j])
                                             : r_mark[j] - 64'(r_pop[j]);
                        end else begin
                            r_lo[j] <= r_fwd ? r_mark[j] + 64'(r_pop[j])
                                             : r_mark[j] - 64'(r_pop[j]);
                        end
                    end
                    if (r_which) begin
                        r_state <= S_NS;
                    end else begin
                        r_which <= 1'b1;
                        r_state <= S_SETUP;
                    end
                end
                S_NS: begin
                    for (int j = 0; j < BASES; j++) begin
                        r_ns[j] <= r_hi[j] - r_lo[j];
                        r_nf[j] <= r_cum[j] + r_lo[j][CNT_W-1:0];
                    end
                    r_tot   <= '0;
                    r_k     <= '0;
                    r_state <= S_TOT;
                end
                S_TOT: begin
                    r_tot <= r_tot + r_ns[r_k];
                    if (r_k == 3'(BASES - 1)) begin
                        r_state <= S_CMP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_CMP: begin
                    // Shift T by one when the '$' lies inside the interval
                    r_nr[3] <= r_rp + CNT_W'($signed(r_tot) < $signed({32'd0, r_sz}));
                    r_k     <= '0;
                    r_state <= S_CHAIN;
                end
                S_CHAIN: begin
                    case (r_k)
                        3'd0:    r_nr[2] <= r_nr[3] + r_ns[3][CNT_W-1:0];
                        3'd1:    r_nr[1] <= r_nr[2] + r_ns[2][CNT_W-1:0];
                        3'd2:    r_nr[0] <= r_nr[1] + r_ns[1][CNT_W-1:0];
                        default: r_nr[4] <= r_nr[0] + r_ns[0][CNT_W-1:0];
                    endcase
                    if (r_k == 3'd3) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: begin
                    if (emit) begin
                        r_ovld  <= 1'b1;
                        r_olast <= !r_all || (r_k == 3'(BASES - 1));
                        r_odata <= {5'd0, o_t, r_ns[o_s][CNT_W-1:0],
                                    r_fwdm ? r_nf[o_s] : r_nr[o_s],
                                    r_fwdm ? r_nr[o_s] : r_nf[o_s]};
                        if (!r_all || (r_k == 3'(BASES - 1))) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_g <= r_gend))
        else $error("rank walk ran past its last group");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output beat changed while stalled");
    a_tag_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_vld |-> ($past(r_state) == S_WALK))
        else $error("memory word tagged outside the walk");
    a_single_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !r_all) |=> (r_state == S_IDLE && o_m_tlast))
        else $error("single extension did not end after one beat");
`endif

endmodule

// File: hdl/fmdx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fmdx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
